>>> design/lindley_queue_delay_estimator_defines.svh
// assertion helpers used by the top-level design file
`ifndef LINDLEY_QUEUE_DELAY_ESTIMATOR_DEFINES_SVH
`define LINDLEY_QUEUE_DELAY_ESTIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LQDE_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lqde check failed");
`define LQDE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lqde check failed");
`else
`define LQDE_ASSERT(label, cond)
`define LQDE_ASSERT_IMPL(label, ante, cons)
`endif

`endif

>>> design/lqde_pkg.sv
package lqde_pkg;

  localparam int TIME_BITS = 48;
  localparam int SIZE_BITS = 16;
  localparam int RATE_BITS = 20;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 20'd1000;
  localparam int BITS_PER_BYTE_NS = 8000;
  // 65535 * 8000 fits in 29 bits
  localparam int SERVICE_BITS = 29;
  localparam int DIGIT_BITS = 4;
  localparam int DIGITS = TIME_BITS / DIGIT_BITS;
  localparam int DIGIT_CNT_BITS = $clog2(DIGITS);
  localparam int DIV_CNT_BITS = $clog2(SERVICE_BITS);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef struct packed {
    logic sum_carry;
    logic borrow;
  } alu_flags_t;

endpackage

>>> design/lindley_queue_delay_estimator.sv
// Lindley-recurrence queueing delay estimator. Each packet transfer carries arrival time,
// size and current time; the block returns one saturated delay per packet plus a flag for
// an arrival earlier than the previous one, never set on a head-of-line packet. Service time,
// size*8000 over the link rate in Mbit/s, comes from a bit-serial restoring divider; the
// interarrival difference runs in the 4-bit digit-serial adder during the division, and the
// final delay takes a second pass of that adder; the next packet waits for both passes.
// The result sits in an output register, so a new packet is accepted while the previous
// delay still waits. A link rate of 0 acts as 1; write it only while idle.
`include "lindley_queue_delay_estimator_defines.svh"

module lindley_queue_delay_estimator
  import lqde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [111:0]         s_tdata,   // arrival_ns[47:0], size_bytes[63:48], now_ns[111:64]
  input  logic                 s_tuser,   // head_of_line
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TIME_BITS-1:0] m_tdata,   // delay_ns[47:0]
  output logic                 m_tuser,   // order_error
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [RATE_BITS-1:0] cfg_data   // link rate in mbit/s
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ALU  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]            state;
  logic [RATE_BITS-1:0]  rate_mbps;
  logic [TIME_BITS-1:0]  running_delay;
  logic [TIME_BITS-1:0]  previous_arrival;
  logic                  head_reg;
  logic [TIME_BITS-1:0]  arr_reg;
  logic [TIME_BITS-1:0]  now_reg;
  logic [TIME_BITS-1:0]  ia_reg;
  logic                  err_reg;
  logic [TIME_BITS-1:0]  delay_res;
  logic                  err_res;

  logic                  in_xfer;
  logic [TIME_BITS-1:0]  in_arrival;
  logic [SIZE_BITS-1:0]  in_size;
  logic [TIME_BITS-1:0]  in_now;
  logic [SERVICE_BITS-1:0] product;

  logic                  div_start;
  logic [SERVICE_BITS-1:0] quotient;
  unit_status_t          div_st;

  logic                  alu_start;
  logic [TIME_BITS-1:0]  alu_x;
  logic [TIME_BITS-1:0]  alu_y;
  logic [TIME_BITS-1:0]  alu_z;
  logic [TIME_BITS-1:0]  alu_result;
  alu_flags_t            alu_fl;
  unit_status_t          alu_st;

  logic                  pass2_start;
  logic [TIME_BITS-1:0]  pass2_x;
  logic [TIME_BITS-1:0]  pass2_z;
  logic [TIME_BITS-1:0]  delay_next;
  logic                  out_free;

  assign in_arrival = s_tdata[47:0];
  assign in_size    = s_tdata[63:48];
  assign in_now     = s_tdata[111:64];

  assign s_tready  = (state == S_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign product = SERVICE_BITS'(in_size) * SERVICE_BITS'(BITS_PER_BYTE_NS);

  assign div_start   = in_xfer;
  assign pass2_start = (state == S_DIV) && div_st.done;
  assign alu_start   = in_xfer || pass2_start;

  // head packet: now + svc - arrival; later ones: delay + svc - interarrival (0 if out of order)
  assign pass2_x = head_reg ? now_reg : running_delay;
  assign pass2_z = head_reg ? arr_reg : (err_reg ? '0 : ia_reg);

  always_comb begin
    if (state == S_IDLE) begin
      alu_x = in_arrival;
      alu_y = '0;
      alu_z = previous_arrival;
    end else begin
      alu_x = pass2_x;
      alu_y = TIME_BITS'(quotient);
      alu_z = pass2_z;
    end
  end

  // sum overflow saturates to all ones, so the delay is then simply ~z
  always_comb begin
    if (alu_fl.sum_carry) begin
      delay_next = ~pass2_z;
    end else if (alu_fl.borrow) begin
      delay_next = '0;
    end else begin
      delay_next = alu_result;
    end
  end

  lqde_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (rate_mbps),
    .quotient (quotient),
    .status   (div_st)
  );

  lqde_digit_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .x      (alu_x),
    .y      (alu_y),
    .z      (alu_z),
    .result (alu_result),
    .flags  (alu_fl),
    .status (alu_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      rate_mbps        <= RATE_RESET;
      running_delay    <= '0;
      previous_arrival <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rate_mbps <= cfg_data;
      end
      // a new result may replace the one leaving in the same cycle
      if (state == S_HOLD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_st.done) begin
            running_delay    <= delay_next;
            previous_arrival <= arr_reg;
            state            <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      head_reg <= s_tuser;
      arr_reg  <= in_arrival;
      now_reg  <= in_now;
    end
    // first pass finishes while the divider is still running
    if (state == S_DIV && alu_st.done) begin
      ia_reg  <= alu_result;
      err_reg <= alu_fl.borrow;
    end
    if (state == S_ALU && alu_st.done) begin
      delay_res <= delay_next;
      err_res   <= !head_reg && err_reg;
    end
    if (state == S_HOLD && out_free) begin
      m_tdata <= delay_res;
      m_tuser <= err_res;
    end
  end

  `LQDE_ASSERT_IMPL(a_idle_units_quiet, state == S_IDLE, !div_st.busy && !alu_st.busy)
  `LQDE_ASSERT_IMPL(a_out_from_hold, $rose(m_tvalid), $past(state) == S_HOLD)
  `LQDE_ASSERT_IMPL(a_head_no_error, state == S_HOLD && head_reg, !err_res)
  `LQDE_ASSERT_IMPL(a_svc_in_alu, state == S_ALU, alu_st.busy || alu_st.done)
  `LQDE_ASSERT_IMPL(a_svc_stable, state == S_ALU, $stable(quotient))

endmodule

>>> design/lqde_divider.sv
module lqde_divider
  import lqde_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [SERVICE_BITS-1:0] dividend,
  input  logic [RATE_BITS-1:0]    divisor,
  output logic [SERVICE_BITS-1:0] quotient,
  output unit_status_t            status
);

  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(SERVICE_BITS - 1);

  logic [SERVICE_BITS-1:0] quo_sh;
  logic [RATE_BITS-1:0]    rem;
  logic [RATE_BITS-1:0]    dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic                    done;

  logic [RATE_BITS:0]      trial;
  logic [RATE_BITS+1:0]    diff;
  logic                    fits;
  logic [RATE_BITS-1:0]    rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem, quo_sh[SERVICE_BITS-1]};
    diff     = {1'b0, trial} - {2'b00, dvs};
    fits     = !diff[RATE_BITS+1];
    rem_next = fits ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= dividend;
      rem    <= '0;
      // zero rate runs as one
      dvs    <= (divisor == '0) ? RATE_BITS'(1) : divisor;
    end else if (busy) begin
      quo_sh <= {quo_sh[SERVICE_BITS-2:0], fits};
      rem    <= rem_next;
    end
  end

  assign quotient    = quo_sh;
  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> design/lqde_digit_alu.sv
module lqde_digit_alu
  import lqde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] x,
  input  logic [TIME_BITS-1:0] y,
  input  logic [TIME_BITS-1:0] z,
  output logic [TIME_BITS-1:0] result,
  output alu_flags_t           flags,
  output unit_status_t         status
);

  localparam logic [DIGIT_CNT_BITS-1:0] DIGIT_LAST = DIGIT_CNT_BITS'(DIGITS - 1);

  logic [TIME_BITS-1:0]      xs;
  logic [TIME_BITS-1:0]      ys;
  logic [TIME_BITS-1:0]      zs;
  logic [TIME_BITS-1:0]      rs;
  logic                      c1;
  logic                      b2;
  logic [DIGIT_CNT_BITS-1:0] cnt;
  logic                      busy;
  logic                      done;

  logic [DIGIT_BITS:0]       s;
  logic [DIGIT_BITS:0]       d;

  // x + y - z, low digit first, carry and borrow kept apart
  always_comb begin
    s = {1'b0, xs[DIGIT_BITS-1:0]} + {1'b0, ys[DIGIT_BITS-1:0]} + (DIGIT_BITS+1)'(c1);
    d = {1'b0, s[DIGIT_BITS-1:0]} - {1'b0, zs[DIGIT_BITS-1:0]} - (DIGIT_BITS+1)'(b2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIGIT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs <= x;
      ys <= y;
      zs <= z;
      c1 <= 1'b0;
      b2 <= 1'b0;
    end else if (busy) begin
      xs <= xs >> DIGIT_BITS;
      ys <= ys >> DIGIT_BITS;
      zs <= zs >> DIGIT_BITS;
      rs <= {d[DIGIT_BITS-1:0], rs[TIME_BITS-1:DIGIT_BITS]};
      c1 <= s[DIGIT_BITS];
      b2 <= d[DIGIT_BITS];
    end
  end

  assign result          = rs;
  assign flags.sum_carry = c1;
  assign flags.borrow    = b2;
  assign status.busy     = busy;
  assign status.done     = done;

endmodule
